>>> rtl/core/i2c_master_byte_sequencer_macros.svh
// Assertion macros for the I2C master byte sequencer checker.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

>>> rtl/core/i2cmbs_pkg.sv
// Shared constants for the I2C master byte sequencer: operation codes,
// step counts and the bit layout of the stream payloads. No dependencies.
package i2cmbs_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Idle shares the tick code.
    localparam logic [2:0] CMD_IDLE = OP_TICK;

    // Final step index of each command.
    localparam logic [4:0] LAST_START = 5'd3;
    localparam logic [4:0] LAST_STOP  = 5'd2;
    localparam logic [4:0] LAST_BYTE  = 5'd28;

    // Step indexes inside the byte sequences.
    localparam logic [4:0] BITS_END_WRITE = 5'd24;
    localparam logic [4:0] BITS_END_READ  = 5'd24;
    localparam logic [4:0] STEP_ACK_SDA   = 5'd25;
    localparam logic [4:0] STEP_ACK_SCLH  = 5'd26;
    localparam logic [4:0] STEP_ACK_MID   = 5'd27;

    // Three-phase bit cell codes.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_MIDDLE = 2'd1;
    localparam logic [1:0] PH_LAST   = 2'd2;

    // Default tick counter width.
    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int STEP_TICKS_WIDTH     = 16;

    // Stream payload widths.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    // Result word layout, lowest bit first.
    localparam int OUT_SCL_BIT  = 0;
    localparam int OUT_SDA_BIT  = 1;
    localparam int OUT_BUSY_BIT = 2;
    localparam int OUT_DONE_BIT = 3;
    localparam int OUT_RX_LSB   = 4;
    localparam int OUT_ACK_BIT  = 12;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

endpackage

>>> rtl/core/i2c_master_byte_sequencer.sv
// I2C master byte sequencer top level: command decode, step sequencer,
// tick divider, APB register and a two-entry result buffer. Uses i2cmbs_pkg.
//
//  Channel   | Direction | Handshake                 | Payload
//  s_axis    | in        | tvalid/tready             | tuser: op; tdata: tx, ack, sda
//  m_axis    | out       | tvalid/tready             | tdata: lines, status, rx byte
//  apb       | in        | psel/penable/pwrite/pready| step_ticks at address 0
//
// Each item's result is registered: the tick divider compare and the step
// decode sit between the state registers and the result register.
// One item is accepted per cycle while the result buffer has room; a held
// result is parked in a skid register, so s_axis_tready drops only when both
// buffer entries are full. Reset is asynchronous and active low; it
// releases both lines and sets step_ticks to one.
module i2c_master_byte_sequencer #(
    parameter int TICK_COUNT_WIDTH = i2cmbs_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: tx_byte[7:0], send_ack[8], sda_in[9], zero fill [15:10].
    input  logic [i2cmbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[2:0].
    input  logic [i2cmbs_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: scl_level[0], sda_drive[1], busy_res[2], done_res[3],
    // rx_byte[11:4], ack_seen[12], zero fill [15:13].
    output logic [i2cmbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cmbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [i2cmbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [i2cmbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);
    import i2cmbs_pkg::*;

    localparam int TW    = TICK_COUNT_WIDTH;
    localparam int CMP_W = (TW > STEP_TICKS_WIDTH) ? TW : STEP_TICKS_WIDTH;
    localparam logic [TW-1:0] TICK_TOP = {TW{1'b1}};

    // Sequencer state.
    logic [2:0]                  cmd_reg, cmd_next;
    logic [4:0]                  step_reg, step_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [TW-1:0]               tick_reg, tick_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;
    logic                        ack_reg, ack_next;
    logic                        ack_choice_reg, ack_choice_next;
    logic [7:0]                  rx_reg, rx_next;
    logic [STEP_TICKS_WIDTH-1:0] step_ticks_reg;

    // Result buffer.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;

    // Decoded input fields.
    logic [2:0] in_op;
    logic [7:0] in_tx;
    logic       in_send_ack;
    logic       in_sda;
    logic       in_fire;
    logic       out_fire;
    logic       is_cmd;
    logic       step_due;
    logic       step_last;
    logic       done;
    logic [TW-1:0]               tick_inc;
    logic [STEP_TICKS_WIDTH-1:0] limit;
    logic [1:0]                  phase_adv;
    logic [2:0]                  bit_pos;
    logic [OUT_DATA_W-1:0]       result;

    assign in_op       = s_axis_tuser[2:0];
    assign in_tx       = s_axis_tdata[7:0];
    assign in_send_ack = s_axis_tdata[8];
    assign in_sda      = s_axis_tdata[9];

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // APB register; writes with paddr[2] set are dropped, all lower addresses write step_ticks.
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(step_ticks_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg <= STEP_TICKS_WIDTH'(1);
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            step_ticks_reg <= pwdata[STEP_TICKS_WIDTH-1:0];
        end
    end

    // Tick divider: a step is due when the count reaches the limit or the top.
    assign tick_inc  = tick_reg + TW'(1);
    assign limit     = (step_ticks_reg == '0) ? STEP_TICKS_WIDTH'(1) : step_ticks_reg;
    assign step_due  = (CMP_W'(tick_inc) >= CMP_W'(limit)) || (tick_inc == TICK_TOP);
    assign phase_adv = (phase_reg == PH_LAST) ? PH_FIRST : phase_reg + 2'd1;
    assign bit_pos   = 3'd7 - bit_reg;
    assign is_cmd    = (in_op == OP_START) || (in_op == OP_STOP) ||
                       (in_op == OP_WRITE) || (in_op == OP_READ);

    // Command decode and one line step per due tick.
    always_comb
    begin
        cmd_next        = cmd_reg;
        step_next       = step_reg;
        bit_next        = bit_reg;
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        tick_next       = tick_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_next        = ack_reg;
        ack_choice_next = ack_choice_reg;
        rx_next         = rx_reg;
        step_last       = 1'b0;
        done            = 1'b0;

        if (is_cmd)
        begin
            // Commands start only when idle; otherwise the item is dropped.
            if (cmd_reg == CMD_IDLE)
            begin
                cmd_next   = in_op;
                step_next  = '0;
                bit_next   = '0;
                phase_next = PH_FIRST;
                tick_next  = '0;
                shift_next = (in_op == OP_WRITE) ? in_tx : 8'h00;
                if (in_op == OP_READ)
                begin
                    ack_choice_next = in_send_ack;
                end
            end
        end
        else if (cmd_reg != CMD_IDLE)
        begin
            if (step_due)
            begin
                tick_next = '0;
                unique case (cmd_reg)
                    OP_START:
                    begin
                        if (step_reg == 5'd0)
                            sda_next = 1'b1;
                        else if (step_reg == 5'd1)
                            scl_next = 1'b1;
                        else if (step_reg == 5'd2)
                            sda_next = 1'b0;
                        else
                            scl_next = 1'b0;
                        step_last = (step_reg >= LAST_START);
                    end
                    OP_STOP:
                    begin
                        if (step_reg == 5'd0)
                            sda_next = 1'b0;
                        else if (step_reg == 5'd1)
                            scl_next = 1'b1;
                        else
                            sda_next = 1'b1;
                        step_last = (step_reg >= LAST_STOP);
                    end
                    OP_WRITE:
                    begin
                        if (step_reg < BITS_END_WRITE)
                        begin
                            // Bit cell: data, clock high, clock low.
                            case (phase_reg)
                                PH_FIRST:  sda_next = shift_reg[bit_pos];
                                PH_MIDDLE: scl_next = 1'b1;
                                default:
                                begin
                                    scl_next = 1'b0;
                                    bit_next = bit_reg + 3'd1;
                                end
                            endcase
                            phase_next = phase_adv;
                        end
                        else if (step_reg <= STEP_ACK_SDA)
                            sda_next = 1'b1;
                        else if (step_reg == STEP_ACK_SCLH)
                            scl_next = 1'b1;
                        else if (step_reg == STEP_ACK_MID)
                            ack_next = !in_sda;
                        else
                            scl_next = 1'b0;
                        step_last = (step_reg >= LAST_BYTE);
                    end
                    OP_READ:
                    begin
                        if (step_reg == 5'd0)
                            sda_next = 1'b1;
                        else if (step_reg <= BITS_END_READ)
                        begin
                            // Bit cell: clock high, sample, clock low.
                            case (phase_reg)
                                PH_FIRST: scl_next = 1'b1;
                                PH_MIDDLE:
                                begin
                                    if (in_sda)
                                        shift_next[bit_pos] = 1'b1;
                                end
                                default:
                                begin
                                    scl_next = 1'b0;
                                    bit_next = bit_reg + 3'd1;
                                end
                            endcase
                            phase_next = phase_adv;
                        end
                        else if (step_reg == STEP_ACK_SDA)
                            sda_next = !ack_choice_reg;
                        else if (step_reg == STEP_ACK_SCLH)
                            scl_next = 1'b1;
                        else if (step_reg == STEP_ACK_MID)
                            scl_next = 1'b0;
                        else
                        begin
                            sda_next = 1'b1;
                            rx_next  = shift_reg;
                        end
                        step_last = (step_reg >= LAST_BYTE);
                    end
                    default: step_last = 1'b1;
                endcase

                if (step_last)
                begin
                    cmd_next  = CMD_IDLE;
                    step_next = '0;
                    bit_next  = '0;
                    done      = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    // Result word built from the updated state.
    always_comb
    begin
        result                                 = '0;
        result[OUT_SCL_BIT]                    = scl_next;
        result[OUT_SDA_BIT]                    = sda_next;
        result[OUT_BUSY_BIT]                   = (cmd_next != CMD_IDLE);
        result[OUT_DONE_BIT]                   = done;
        result[OUT_RX_LSB+7:OUT_RX_LSB]        = rx_next;
        result[OUT_ACK_BIT]                    = ack_next;
    end

    // State registers advance on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_IDLE;
            step_reg       <= '0;
            bit_reg        <= '0;
            phase_reg      <= PH_FIRST;
            shift_reg      <= '0;
            tick_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_reg        <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_reg         <= '0;
        end
        else if (in_fire)
        begin
            cmd_reg        <= cmd_next;
            step_reg       <= step_next;
            bit_reg        <= bit_next;
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            tick_reg       <= tick_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_reg        <= ack_next;
            ack_choice_reg <= ack_choice_next;
            rx_reg         <= rx_next;
        end
    end

    // Two-entry result buffer: output register plus skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = skid_data_reg;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/core/i2cmbs_checker.sv
// Port-level checker for the I2C master byte sequencer and its bind.
// Uses i2cmbs_pkg and the macros in i2c_master_byte_sequencer_macros.svh.
`include "i2c_master_byte_sequencer_macros.svh"

module i2cmbs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [i2cmbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [i2cmbs_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [i2cmbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [i2cmbs_pkg::APB_ADDR_W-1:0] paddr,
    input logic [i2cmbs_pkg::APB_DATA_W-1:0] pwdata,
    input logic [i2cmbs_pkg::APB_DATA_W-1:0] prdata,
    input logic                              pready
);
    import i2cmbs_pkg::*;

    // A stalled result item keeps its payload.
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")

    // Input backpressure only appears while a result is waiting.
    `ASSERT_IMPL(a_ready_full, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")

    // A finished command is never reported as still busy.
    `ASSERT_IMPL(a_done_idle, m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT], !m_axis_tdata[OUT_BUSY_BIT], "done reported while busy")

    // The register port never inserts wait states.
    `ASSERT_IMPL(a_pready_high, psel && penable, pready, "configuration access stalled")

endmodule

bind i2c_master_byte_sequencer i2cmbs_checker u_i2cmbs_checker (.*);

>>> dv/i2c_master_byte_sequencer_test.sv
// Self-checking testbench for i2c_master_byte_sequencer: drives command and tick
// items on the input stream, predicts the line levels of every result item and
// checks them. Depends on i2cmbs_pkg and the block's RTL.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_test;
    import i2cmbs_pkg::*;

    // Operation codes outside the defined set; the block treats them as ticks.
    localparam logic [2:0]  OP_SPARE_LO     = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI     = 3'd7;
    localparam logic [2:0]  STEP_TICKS_ADDR = 3'd0;
    localparam logic [15:0] COUNT_TOP       = 16'hFFFF;
    localparam int          LONG_HOLD       = 300;
    localparam int          TAIL_CYCLES     = 20;
    localparam longint      CYCLE_LIMIT     = 4000000;

    // Expected contents of one result item, last field in the lowest bit.
    typedef struct packed {
        logic       ack_seen;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_level;
    } line_state_t;

    // Predicts the bus line levels and status after every accepted item and
    // checks the result items against them in order.
    class i2c_line_predictor;
        logic [15:0] step_ticks;
        logic [4:0]  step_idx;
        logic [2:0]  bit_idx;
        logic [2:0]  cmd;
        logic [7:0]  shift_reg;
        logic [15:0] tick_cnt;
        logic        scl;
        logic        sda;
        logic        ack_flag;
        logic        ack_choice;
        logic [7:0]  rx_hold;
        line_state_t expected_lines[$];
        int          mismatches;

        function new();
            step_ticks = 16'd1;
            step_idx   = '0;
            bit_idx    = '0;
            cmd        = CMD_IDLE;
            shift_reg  = '0;
            tick_cnt   = '0;
            scl        = 1'b1;
            sda        = 1'b1;
            ack_flag   = 1'b0;
            ack_choice = 1'b0;
            rx_hold    = '0;
            mismatches = 0;
        endfunction

        function void set_step_ticks(logic [15:0] value);
            step_ticks = value;
        endfunction

        function bit is_busy();
            return cmd != CMD_IDLE;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        // Carries out the current step of the command; returns 1 on its last step.
        function bit take_step(logic sda_in);
            int         s;
            int         ph;
            logic [7:0] mask;
            s    = int'(step_idx);
            mask = 8'h80 >> bit_idx;
            case (cmd)
                OP_START:
                begin
                    if (s == 0) sda = 1'b1;
                    else if (s == 1) scl = 1'b1;
                    else if (s == 2) sda = 1'b0;
                    else scl = 1'b0;
                    return s >= LAST_START;
                end
                OP_STOP:
                begin
                    if (s == 0) sda = 1'b0;
                    else if (s == 1) scl = 1'b1;
                    else sda = 1'b1;
                    return s >= LAST_STOP;
                end
                OP_WRITE:
                begin
                    if (s < BITS_END_WRITE)
                    begin
                        ph = s % 3;
                        if (ph == PH_FIRST) sda = |(shift_reg & mask);
                        else if (ph == PH_MIDDLE) scl = 1'b1;
                        else
                        begin
                            scl     = 1'b0;
                            bit_idx = bit_idx + 3'd1;
                        end
                    end
                    else if (s <= STEP_ACK_SDA) sda = 1'b1;
                    else if (s == STEP_ACK_SCLH) scl = 1'b1;
                    else if (s == STEP_ACK_MID) ack_flag = !sda_in;
                    else scl = 1'b0;
                    return s >= LAST_BYTE;
                end
                OP_READ:
                begin
                    if (s == 0) sda = 1'b1;
                    else if (s <= BITS_END_READ)
                    begin
                        ph = (s - 1) % 3;
                        if (ph == PH_FIRST) scl = 1'b1;
                        else if (ph == PH_MIDDLE)
                        begin
                            if (sda_in) shift_reg = shift_reg | mask;
                        end
                        else
                        begin
                            scl     = 1'b0;
                            bit_idx = bit_idx + 3'd1;
                        end
                    end
                    else if (s == STEP_ACK_SDA) sda = !ack_choice;
                    else if (s == STEP_ACK_SCLH) scl = 1'b1;
                    else if (s == STEP_ACK_MID) scl = 1'b0;
                    else
                    begin
                        sda     = 1'b1;
                        rx_hold = shift_reg;
                    end
                    return s >= LAST_BYTE;
                end
                default:
                    return 1'b1;
            endcase
        endfunction

        // Updates the state for one accepted input item and queues its result.
        function void note_item(logic [2:0] op, logic [7:0] tx, logic ack_in, logic sda_in);
            line_state_t res;
            logic [15:0] limit;
            logic [15:0] nxt;
            bit          done;
            done = 1'b0;
            if (op >= OP_START && op <= OP_READ)
            begin
                // A command is taken only while idle; otherwise it is dropped.
                if (cmd == CMD_IDLE)
                begin
                    cmd       = op;
                    step_idx  = '0;
                    bit_idx   = '0;
                    tick_cnt  = '0;
                    shift_reg = (op == OP_WRITE) ? tx : 8'h00;
                    if (op == OP_READ) ack_choice = ack_in;
                end
            end
            else if (cmd != CMD_IDLE)
            begin
                limit = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
                nxt   = tick_cnt + 16'd1;
                if (nxt >= limit || nxt == COUNT_TOP)
                begin
                    tick_cnt = '0;
                    if (take_step(sda_in))
                    begin
                        cmd      = CMD_IDLE;
                        step_idx = '0;
                        bit_idx  = '0;
                        done     = 1'b1;
                    end
                    else
                        step_idx = step_idx + 5'd1;
                end
                else
                    tick_cnt = nxt;
            end
            res.scl_level = scl;
            res.sda_drive = sda;
            res.busy_res  = (cmd != CMD_IDLE);
            res.done_res  = done;
            res.rx_byte   = rx_hold;
            res.ack_seen  = ack_flag;
            expected_lines.push_back(res);
        endfunction

        // Compares one result item with the oldest expected line state.
        function void check_lines(logic [OUT_DATA_W-1:0] word);
            line_state_t want;
            line_state_t got;
            if (expected_lines.size() == 0)
            begin
                $error("result item 0x%04h arrived with no expectation waiting", word);
                mismatches++;
                return;
            end
            want = expected_lines.pop_front();
            got  = word[$bits(line_state_t)-1:0];
            if (got.scl_level !== want.scl_level)
            begin
                $error("scl_level expected %0d got %0d", want.scl_level, got.scl_level);
                mismatches++;
            end
            if (got.sda_drive !== want.sda_drive)
            begin
                $error("sda_drive expected %0d got %0d", want.sda_drive, got.sda_drive);
                mismatches++;
            end
            if (got.busy_res !== want.busy_res)
            begin
                $error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
                mismatches++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res expected %0d got %0d", want.done_res, got.done_res);
                mismatches++;
            end
            if (got.rx_byte !== want.rx_byte)
            begin
                $error("rx_byte expected 0x%02h got 0x%02h", want.rx_byte, got.rx_byte);
                mismatches++;
            end
            if (got.ack_seen !== want.ack_seen)
            begin
                $error("ack_seen expected %0d got %0d", want.ack_seen, got.ack_seen);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    i2c_line_predictor lines = new();
    int     failures;
    int     items_sent;
    int     src_idle_pct;
    int     sink_idle_pct;
    int     hold_requested;
    int     hold_served;
    int     hold_left;
    longint cycle_count;

    i2c_master_byte_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run time guard.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requested)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every accepted result item is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lines.check_lines(m_axis_tdata);
    end

    // Offers one item, waits until it is taken and records it in the predictor.
    task automatic send_item(logic [2:0] op, logic [7:0] tx, logic ack_in, logic sda_in);
        bit ignored;
        // Each idle cycle is drawn on its own, so the idle share matches the percentage.
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, sda_in, ack_in, tx};
        do @(posedge clk); while (!s_axis_tready);
        ignored = (op >= OP_START && op <= OP_READ) && lines.is_busy();
        lines.note_item(op, tx, ack_in, sda_in);
        if (!ignored) items_sent++;
    endtask

    // Sends plain ticks until the running command has finished.
    task automatic finish_command();
        while (lines.is_busy())
            send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Stops offering items until every expected result has come back.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (lines.pending() != 0);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("step_ticks readback expected %0d got %0d", want, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes the tick divider once the block has gone quiet.
    task automatic change_step_ticks(logic [15:0] value);
        finish_command();
        wait_results();
        apb_write(STEP_TICKS_ADDR, {16'b0, value});
        lines.set_step_ticks(value);
        apb_read_check(STEP_TICKS_ADDR, {16'b0, value});
    endtask

    // One complete command with random content, mixed with stray commands
    // and spare operation codes while it runs.
    task automatic run_transaction();
        logic [2:0] op;
        logic [7:0] tx;
        int         r;
        op = OP_START + 3'($urandom_range(3));
        r  = $urandom_range(9);
        tx = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        send_item(op, tx, 1'($urandom_range(1)), 1'($urandom_range(1)));
        while (lines.is_busy())
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_item(OP_START + 3'($urandom_range(3)), 8'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (r < 9)
                send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
    endtask

    // Random part of one phase: mostly whole commands, some raw noise.
    task automatic run_random(int count);
        int first;
        first = items_sent;
        while (items_sent - first < count)
        begin
            if ($urandom_range(99) < 80)
                run_transaction();
            else
                repeat ($urandom_range(1, 4))
                    send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            if ($urandom_range(49) == 0) wait_results();
        end
        finish_command();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_TICK;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        failures       = 0;
        items_sent     = 0;
        hold_requested = 0;
        hold_served    = 0;
        hold_left      = 0;
        src_idle_pct   = 16;
        sink_idle_pct  = 75;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(STEP_TICKS_ADDR, 32'd1);

        // Directed: idle ticks, spare codes, a start with stray commands
        // while busy, then a stop with a stray stop.
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_item(OP_SPARE_LO, 8'hFF, 1'b1, 1'b1);
        send_item(OP_SPARE_HI, 8'h00, 1'b0, 1'b0);
        send_item(OP_START, 8'h00, 1'b0, 1'b1);
        send_item(OP_READ, 8'hFF, 1'b1, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_item(OP_SPARE_LO + 3'd1, 8'hAA, 1'b1, 1'b0);
        send_item(OP_WRITE, 8'h55, 1'b0, 1'b1);
        send_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_item(OP_STOP, 8'h00, 1'b0, 1'b0);
        send_item(OP_STOP, 8'hFF, 1'b1, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_item(OP_TICK, 8'hFF, 1'b1, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b0);

        run_random(350);
        // A zero divider behaves like one.
        change_step_ticks(16'd0);
        run_random(300);

        src_idle_pct  = 75;
        sink_idle_pct = 16;
        change_step_ticks(16'd2);
        run_random(150);
        hold_requested++;
        run_random(20);
        wait_results();
        run_random(130);
        change_step_ticks(16'd1);
        run_random(150);

        // No idling on either side; a long receiver hold-off backs up the input.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        change_step_ticks(16'd4);
        hold_requested++;
        run_random(250);

        // Largest divider: a stop is started and a short run of ticks keeps
        // its counter climbing well short of the first step.
        change_step_ticks(COUNT_TOP);
        send_item(OP_STOP, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (TAIL_CYCLES)
            send_item(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && lines.mismatches == 0 && lines.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> i2c_master_byte_sequencer.f
+incdir+rtl/core
rtl/core/i2cmbs_pkg.sv
rtl/core/i2c_master_byte_sequencer.sv
rtl/core/i2cmbs_checker.sv
dv/i2c_master_byte_sequencer_test.sv
